// ----- sv/bda_pkg.sv -----
// Shared constants and types for the binary to decimal ASCII converter.
package bda_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned STORE_DEPTH = 10;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 7'd45;

  // floor(x / 10) == (x * RECIP_TEN) >> DIV_SHIFT for every 32-bit x.
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned        DIV_SHIFT = 35;
  localparam int unsigned        QUO_W     = 2*VALUE_W - DIV_SHIFT;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } back_state_t;

endpackage

// ----- sv/bda_if.sv -----
// Handshake channel interfaces for the converter's input and result sides.
interface bda_in_if;
  import bda_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               signed_mode;

  modport source (output valid, output value, output signed_mode, input ready);
  modport sink   (input valid, input value, input signed_mode, output ready);
endinterface

interface bda_out_if;
  import bda_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- sv/bda_front.sv -----
// Front end: accepts words, splits them into sign and magnitude, and queues them.
module bda_front
  import bda_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  bda_in_if.sink      in_chan,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_pop
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QDEPTH + 1);

  job_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              push, pop;
  job_t              new_job;

  // A negative two's complement word is replaced by its magnitude modulo 2^32.
  always_comb begin
    new_job.neg = in_chan.signed_mode & in_chan.value[VALUE_W-1];
    new_job.mag = new_job.neg ? (~in_chan.value + VALUE_W'(1)) : in_chan.value;
  end

  assign in_chan.ready = (count_r != CNT_QW'(QDEPTH));
  assign push          = in_chan.valid & in_chan.ready;
  assign job_valid     = (count_r != '0);
  assign pop           = job_pop & job_valid;
  assign job           = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_QW'(push) - CNT_QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_QW'(QDEPTH))
    else $error("queue count exceeds its depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_QW'(1))
    else $error("queue count missed a push");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> wr_ptr_r == rd_ptr_r)
    else $error("empty queue with unequal pointers");

endmodule

// ----- sv/bda_back.sv -----
// Back end: peels decimal digits off a magnitude, sends a char a cycle unless stalled.
module bda_back
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  bda_out_if.source   out_chan
);

  back_state_t         state_r, state_nxt;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic                sign_r, sign_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [DIGIT_W-1:0]  digit_store [STORE_DEPTH];

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quo;
  logic [VALUE_W-1:0]   rem;
  logic [DIGIT_W-1:0]   digit;
  logic [CNT_W-1:0]     idx;
  logic                 store_wr;
  logic                 load;

  // Divide by ten with a reciprocal multiply; the remainder is the new digit.
  assign prod  = (2*VALUE_W)'(mag_r) * (2*VALUE_W)'(RECIP_TEN);
  assign quo   = VALUE_W'(prod[2*VALUE_W-1:DIV_SHIFT]);
  assign rem   = mag_r - ((quo << 3) + (quo << 1));
  assign digit = rem[DIGIT_W-1:0];
  assign idx   = left_r - CNT_W'(1);

  assign load     = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);
  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign store_wr = (state_r == S_CONV);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    sign_nxt      = sign_r;
    left_nxt      = left_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          mag_nxt   = job.mag;
          sign_nxt  = job.neg;
          left_nxt  = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // Digits land least significant first; a zero magnitude still yields one.
        mag_nxt  = quo;
        left_nxt = left_r + CNT_W'(1);
        if (quo == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (sign_r) begin
            out_char_nxt = CHR_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = CHR_ZERO + CHAR_W'(digit_store[idx[IDX_W-1:0]]);
            out_last_nxt = (idx == '0);
            left_nxt     = idx;
            if (idx == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sign_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_r      <= sign_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (store_wr) begin
      digit_store[left_r[IDX_W-1:0]] <= digit;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.char_code = out_char_r;
  assign out_chan.last_char = out_last_r;

  a_conv_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> left_r < CNT_W'(STORE_DEPTH))
    else $error("digit count ran past the store");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (left_r != '0 && left_r <= CNT_W'(STORE_DEPTH)))
    else $error("emitting with no digits left");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHR_MINUS) |-> !out_last_r)
    else $error("minus sign marked as the last character");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !sign_r && idx == '0) |=> (state_r == S_IDLE && !sign_r))
    else $error("final digit sent without returning to idle");

endmodule

// ----- sv/binary_to_decimal_ascii.sv -----
// Top level of the 32-bit binary to decimal ASCII converter.
//
// in_chan takes one word (value, signed_mode) per item. With signed_mode set
// a word with bit 31 high is printed as '-' followed by its magnitude;
// otherwise the word is printed as an unsigned number.
// out_chan gives the text one character per item, most significant digit
// first, no leading zeros; zero prints as "0". last_char marks the final one.
// A two-entry queue holds words in sign and magnitude form; the back end
// takes one, peels off its decimal digits (1 to 10 of them) one by one in a
// multiply-by-reciprocal divide by ten, then loads one character a cycle into
// the output register unless the receiver stalls. It takes no new word until
// the last character of an item is loaded.
// When the receiver stalls, the output register holds its character and the
// queue keeps taking words until both entries are full.
// Synchronous reset empties the queue, clears the output valid and returns
// the back end to idle; nothing else needs clearing.
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  bda_in_if.sink     in_chan,
  bda_out_if.source  out_chan
);

  logic job_valid;
  logic job_pop;
  job_t job;

  bda_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  bda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_chan  (out_chan)
  );

endmodule
